@@ hdl/alr_pkg.sv @@
// Shared codes, widths and types for the array list with cursor.
`default_nettype none
package alr_pkg;

  localparam int CMD_W  = 2;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_OUT_W = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIRST  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_END   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOCUR = 2'd3;

  typedef struct packed {
    logic ins;
    logic shift;
  } alr_op_t;

endpackage
`default_nettype wire

@@ hdl/alr_cmd_if.sv @@
// Command channel: valid, ready and one command beat.
`default_nettype none
interface alr_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [alr_pkg::CMD_W-1:0]  command;
  logic signed [alr_pkg::DATA_W-1:0] value_in;

  modport source (output valid, output command, output value_in, input ready);
  modport sink   (input valid, input command, input value_in, output ready);
endinterface
`default_nettype wire

@@ hdl/alr_res_if.sv @@
// Result channel: valid, ready and one result beat.
`default_nettype none
interface alr_res_if;
  logic                          valid;
  logic                          ready;
  logic [alr_pkg::STAT_W-1:0]    status;
  logic signed [alr_pkg::DATA_W-1:0] value_out;
  logic [alr_pkg::CNT_OUT_W-1:0] count;

  modport source (output valid, output status, output value_out, output count, input ready);
  modport sink   (input valid, input status, input value_out, input count, output ready);
endinterface
`default_nettype wire

@@ hdl/alr_cell.sv @@
// One list entry: load on insert, take the upper neighbor on remove, drive it on read.
`default_nettype none
module alr_cell #(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  wire logic                       clk,
  input  wire alr_pkg::alr_op_t           op,
  input  wire logic [IDX_W-1:0]           wr_idx,
  input  wire logic [IDX_W-1:0]           cur_idx,
  input  wire logic [IDX_W-1:0]           rd_idx,
  input  wire logic [alr_pkg::DATA_W-1:0] wr_data,
  input  wire logic [alr_pkg::DATA_W-1:0] nb_data,
  output logic      [alr_pkg::DATA_W-1:0] data,
  output logic      [alr_pkg::DATA_W-1:0] rd_data
);
  import alr_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  always_ff @(posedge clk) begin
    if (op.ins && wr_idx == MY_IDX) begin
      data <= wr_data;
    end else if (op.shift && MY_IDX >= cur_idx) begin
      data <= nb_data;
    end
  end

  assign rd_data = (rd_idx == MY_IDX) ? data : '0;

endmodule
`default_nettype wire

@@ hdl/array_list_with_cursor_core.sv @@
// Top level of the array list with cursor: control, cursor, count and the row of cells.
//   channel  dir  beat
//   cmd      in   command, value_in
//   res      out  status, value_out, count
// A result register holds each command's result until it is taken.
// A new command is taken while the result register is empty or being emptied.
// Remove shifts every later cell down by one in the same cycle.
// Synchronous reset empties the list and drops the cursor; cells are not cleared.
`default_nettype none
module array_list_with_cursor_core #(
  parameter int DEPTH = 64
) (
  input wire logic clk,
  input wire logic rst,
  alr_cmd_if.sink   cmd,
  alr_res_if.source res
);
  import alr_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]  stored_count, stored_count_next;
  logic              cur_valid, cur_valid_next;
  logic [IDX_W-1:0]  cursor, cursor_next;
  logic              out_valid;
  logic [STAT_W-1:0] out_status, status_next;
  logic [DATA_W-1:0] out_value, value_next;
  logic [CNT_OUT_W-1:0] out_count;

  logic              accept;
  logic [CNT_W-1:0]  nxt;
  logic [IDX_W-1:0]  rd_idx;
  logic [DATA_W-1:0] rd_value;
  alr_op_t           op;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_rd   [DEPTH];

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !out_valid || res.ready;
  assign nxt       = cur_valid ? (CNT_W'(cursor) + CNT_W'(1)) : '0;

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_value = rd_value | cell_rd[i];
    end
  end

  always_comb begin
    stored_count_next = stored_count;
    cur_valid_next    = cur_valid;
    cursor_next       = cursor;
    status_next       = ST_OK;
    value_next        = '0;
    rd_idx            = '0;
    op                = '0;
    case (cmd.command)
      CMD_INSERT: begin
        if (stored_count == FULL_CNT) begin
          status_next = ST_FULL;
        end else begin
          op.ins            = accept;
          stored_count_next = stored_count + CNT_W'(1);
        end
      end
      CMD_FIRST: begin
        if (stored_count == '0) begin
          status_next = ST_END;
        end else begin
          cur_valid_next = 1'b1;
          cursor_next    = '0;
          value_next     = rd_value;
        end
      end
      CMD_NEXT: begin
        rd_idx = IDX_W'(nxt);
        if (nxt >= stored_count) begin
          status_next = ST_END;
        end else begin
          cur_valid_next = 1'b1;
          cursor_next    = IDX_W'(nxt);
          value_next     = rd_value;
        end
      end
      CMD_REMOVE: begin
        rd_idx = cursor;
        if (!cur_valid || CNT_W'(cursor) >= stored_count) begin
          status_next = ST_NOCUR;
        end else begin
          op.shift          = accept;
          value_next        = rd_value;
          stored_count_next = stored_count - CNT_W'(1);
          if (cursor == '0) begin
            cur_valid_next = 1'b0;
          end else begin
            cursor_next = cursor - IDX_W'(1);
          end
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    alr_cell #(
      .IDX_W (IDX_W),
      .IDX   (g)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .wr_idx  (IDX_W'(stored_count)),
      .cur_idx (cursor),
      .rd_idx  (rd_idx),
      .wr_data (cmd.value_in),
      .nb_data ((g + 1 < DEPTH) ? cell_data[(g + 1 < DEPTH) ? g + 1 : g] : cell_data[g]),
      .data    (cell_data[g]),
      .rd_data (cell_rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      cur_valid    <= 1'b0;
      cursor       <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        stored_count <= stored_count_next;
        cur_valid    <= cur_valid_next;
        cursor       <= cursor_next;
        out_valid    <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_value  <= value_next;
      out_count  <= CNT_OUT_W'(stored_count_next);
    end
  end

  assign res.valid     = out_valid;
  assign res.status    = out_status;
  assign res.value_out = out_value;
  assign res.count     = out_count;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= FULL_CNT)
    else $error("stored count above depth");

  a_cursor_in_list: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (CNT_W'(cursor) < stored_count))
    else $error("cursor past last entry");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.command == CMD_INSERT && stored_count != FULL_CNT)
      |=> stored_count == $past(stored_count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_remove_nocur: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.command == CMD_REMOVE && !cur_valid)
      |=> (out_status == ST_NOCUR && stored_count == $past(stored_count)))
    else $error("remove without cursor not refused");
`endif

endmodule
`default_nettype wire
